[hdl/tlbp_pkg.sv]
// Shared types and constants for the texel layer blend paint block.
// Holds the configuration record, the pipeline word record and fixed-point sizes.
// No dependencies.
package tlbp_pkg;

    localparam int MAX_LAYERS = 4;
    localparam int CW         = 24;
    localparam int SW         = 26;
    localparam int QW         = 25;
    localparam int DW         = 27;
    localparam int NUM_W      = QW + DW;

    localparam logic [CW-1:0] FULL_Q16  = 24'd16711680;
    localparam logic [SW-1:0] EPS_Q16   = 26'd65;
    localparam logic [15:0]   MAX_FIXED = 16'd65280;
    localparam logic [7:0]    FULL_BYTE = 8'd255;
    localparam logic [16:0]   W_ONE     = 17'd65536;
    localparam logic [8:0]    RATE_ONE  = 9'd256;

    localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] REG_PAINT_LAYER = 3'd1;
    localparam logic [2:0] REG_FALLOFF     = 3'd2;
    localparam logic [2:0] REG_RADIUS      = 3'd3;
    localparam logic [2:0] REG_RATE        = 3'd4;
    localparam logic [2:0] REG_TOWARD      = 3'd5;

    localparam logic [1:0] FALLOFF_FLAT   = 2'd0;
    localparam logic [1:0] FALLOFF_LINEAR = 2'd1;

    typedef struct packed {
        logic [2:0]  layer_count;
        logic [1:0]  paint_layer;
        logic [1:0]  falloff_mode;
        logic [15:0] brush_radius;
        logic [8:0]  blend_rate;
        logic        paint_toward_full;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        layer_count:       3'd2,
        paint_layer:       2'd1,
        falloff_mode:      2'd2,
        brush_radius:      16'd256,
        blend_rate:        9'd64,
        paint_toward_full: 1'b1
    };

    typedef struct packed {
        logic                          vld;
        logic                          ok;
        logic                          mod;
        logic [2:0][15:0]              cov;
        logic [16:0]                   t;
        logic [16:0]                   t2;
        logic [16:0]                   w;
        logic [16:0]                   st;
        logic [MAX_LAYERS-1:0][CW-1:0] c;
        logic [SW-1:0]                 total;
        logic [SW-1:0]                 others;
        logic [SW-1:0]                 change;
        logic [SW-1:0]                 after;
    } pipe_t;

endpackage

[hdl/tlbp_cfg.sv]
// APB register file for the blend paint block.
// Depends on tlbp_pkg for the configuration record and register codes.
module tlbp_cfg import tlbp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic [31:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LAYER_COUNT: cfg_reg.layer_count       <= pwdata[2:0];
                REG_PAINT_LAYER: cfg_reg.paint_layer       <= pwdata[1:0];
                REG_FALLOFF:     cfg_reg.falloff_mode      <= pwdata[1:0];
                REG_RADIUS:      cfg_reg.brush_radius      <= pwdata[15:0];
                REG_RATE:        cfg_reg.blend_rate        <= pwdata[8:0];
                REG_TOWARD:      cfg_reg.paint_toward_full <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LAYER_COUNT: rd_val = {29'd0, cfg_reg.layer_count};
            REG_PAINT_LAYER: rd_val = {30'd0, cfg_reg.paint_layer};
            REG_FALLOFF:     rd_val = {30'd0, cfg_reg.falloff_mode};
            REG_RADIUS:      rd_val = {16'd0, cfg_reg.brush_radius};
            REG_RATE:        rd_val = {23'd0, cfg_reg.blend_rate};
            REG_TOWARD:      rd_val = {31'd0, cfg_reg.paint_toward_full};
            default:         rd_val = 32'd0;
        endcase
        prdata = (paddr[1:0] == 2'd0) ? rd_val : 32'd0;
    end

endmodule

[hdl/tlbp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, four lanes on one divisor.
// Carries a pipeline word alongside; depends on tlbp_pkg.
module tlbp_div import tlbp_pkg::*; (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic [MAX_LAYERS-1:0][NUM_W-1:0] num,
    input  logic [DW-1:0]                    den,
    input  pipe_t                            tag_in,
    output logic [MAX_LAYERS-1:0][QW-1:0]    quo,
    output pipe_t                            tag_out
);

    logic [MAX_LAYERS-1:0][DW-1:0] rem_reg [QW];
    logic [MAX_LAYERS-1:0][DW-1:0] rem_next [QW];
    logic [MAX_LAYERS-1:0][QW-1:0] nq_reg [QW];
    logic [MAX_LAYERS-1:0][QW-1:0] nq_next [QW];
    logic [DW-1:0]                 den_reg [QW];
    logic [DW-1:0]                 den_next [QW];
    pipe_t                         tag_reg [QW];
    pipe_t                         tag_next [QW];

    always_comb begin
        logic [DW-1:0] ri;
        logic [QW-1:0] qi;
        logic [DW:0]   r2;
        logic [DW:0]   df;
        logic [DW-1:0] dk;
        logic          qb;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                dk          = den;
                tag_next[k] = tag_in;
            end else begin
                dk          = den_reg[k-1];
                tag_next[k] = tag_reg[k-1];
            end
            den_next[k] = dk;
            for (int l = 0; l < MAX_LAYERS; l++) begin
                if (k == 0) begin
                    ri = num[l][NUM_W-1:QW];
                    qi = num[l][QW-1:0];
                end else begin
                    ri = rem_reg[k-1][l];
                    qi = nq_reg[k-1][l];
                end
                r2 = {ri, qi[QW-1]};
                df = r2 - {1'b0, dk};
                qb = (r2 >= {1'b0, dk});
                rem_next[k][l] = qb ? df[DW-1:0] : r2[DW-1:0];
                nq_next[k][l]  = {qi[QW-2:0], qb};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QW; k++) begin
                tag_reg[k].vld <= 1'b0;
            end
        end else if (en) begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
            den_reg <= den_next;
            tag_reg <= tag_next;
        end
    end

    assign quo     = nq_reg[QW-1];
    assign tag_out = tag_reg[QW-1];

endmodule

[hdl/tlbp_weight.sv]
// Brush weight stages: smoothstep terms, falloff select, stroke strength, layer split.
// Depends on tlbp_pkg; fed by the ramp divider.
module tlbp_weight import tlbp_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  cfg_t          cfg,
    input  pipe_t         tag_in,
    input  logic [QW-1:0] t_quo,
    output pipe_t         tag_out
);

    pipe_t s1_reg, s1_next;
    pipe_t s2_reg, s2_next;
    pipe_t s3_reg, s3_next;

    always_comb begin
        logic [33:0] sq;
        logic [33:0] sq_r;
        s1_next   = tag_in;
        s1_next.t = t_quo[16:0];
        sq        = 34'(t_quo[16:0]) * 34'(t_quo[16:0]);
        sq_r      = (sq + 34'd32768) >> 16;
        s1_next.t2 = sq_r[16:0];
    end

    always_comb begin
        logic [17:0] poly;
        logic [33:0] sm;
        logic [33:0] sm_r;
        s2_next = s1_reg;
        poly    = 18'd196608 - {s1_reg.t, 1'b0};
        sm      = 34'(s1_reg.t2) * 34'(poly);
        sm_r    = (sm + 34'd32768) >> 16;
        case (cfg.falloff_mode)
            FALLOFF_FLAT:   s2_next.w = W_ONE;
            FALLOFF_LINEAR: s2_next.w = s1_reg.t;
            default:        s2_next.w = sm_r[16:0];
        endcase
    end

    always_comb begin
        logic [8:0]    rate;
        logic [25:0]   sp;
        logic [SW-1:0] sum13;
        s3_next = s2_reg;
        rate    = (cfg.blend_rate > RATE_ONE) ? RATE_ONE : cfg.blend_rate;
        sp      = (26'(s2_reg.w) * 26'(rate) + 26'd128) >> 8;
        s3_next.st = sp[16:0];
        for (int l = 1; l < MAX_LAYERS; l++) begin
            s3_next.c[l] = (3'(l) < cfg.layer_count) ? {s2_reg.cov[l-1], 8'h00} : '0;
        end
        sum13 = SW'(s3_next.c[1]) + SW'(s3_next.c[2]) + SW'(s3_next.c[3]);
        s3_next.c[0]  = (sum13 >= SW'(FULL_Q16)) ? '0 : CW'(SW'(FULL_Q16) - sum13);
        s3_next.total = sum13 + SW'(s3_next.c[0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.vld <= 1'b0;
            s2_reg.vld <= 1'b0;
            s3_reg.vld <= 1'b0;
        end else if (en) begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
        end
    end

    assign tag_out = s3_reg;

endmodule

[hdl/texel_layer_blend_paint.sv]
// Channel   | Dir | Ports                       | Word
// s_        | in  | s_tvalid/s_tready/s_tdata   | distance, coverage of layers 1..3
// m_        | out | m_tvalid/m_tready/m_tdata   | new coverage 1..3, bytes 1..3
//           |     | m_tuser                     | texel modified flag
// apb       | cfg | psel/penable/pwrite/paddr   | six registers at 4-byte steps
// Words enter one per cycle while no output is held, through three 25-stage
// dividers (brush ramp, share, renormalize) plus ten arithmetic stages.
// Reset clears every valid bit and loads the register defaults.
// A held output word freezes the whole pipeline; s_tready drops while it is held.
// Top level of the texel layer blend paint block; uses tlbp_pkg, tlbp_cfg,
// tlbp_div and tlbp_weight.
module texel_layer_blend_paint import tlbp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // texel_distance, layer1/2/3_coverage
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // layer1/2/3_coverage_new, layer1/2/3_alpha_byte
    output logic [0:0]  m_tuser,   // texel_modified
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t  cfg;
    logic  pipe_en;
    logic  cfg_ok;

    pipe_t s0_reg, s0_next;
    pipe_t diva_tag, w_tag;
    pipe_t s4_reg, s4_next;
    pipe_t s5_reg, s5_next;
    pipe_t s6_reg, s6_next;
    pipe_t divb_tag;
    pipe_t s7_reg, s7_next;
    pipe_t s8_reg, s8_next;
    pipe_t divc_tag;

    logic [15:0] s_dist;
    logic [15:0] s0_diff_reg, s0_diff_next;

    logic signed [43:0] prod_reg, prod_next;
    logic [MAX_LAYERS-1:0][48:0] mul_reg, mul_next;

    logic [MAX_LAYERS-1:0][NUM_W-1:0] diva_num, divb_num, divc_num;
    logic [MAX_LAYERS-1:0][QW-1:0]    diva_quo, divb_quo, divc_quo;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg;

    function automatic logic [15:0] sat_fixed(input logic [15:0] v);
        return (v > MAX_FIXED) ? MAX_FIXED : v;
    endfunction

    function automatic logic [7:0] byte_of_fixed(input logic [15:0] v);
        logic [16:0] b;
        b = (17'(v) + 17'd128) >> 8;
        return (b > 17'(FULL_BYTE)) ? FULL_BYTE : b[7:0];
    endfunction

    function automatic logic [15:0] fixed_of_q16(input logic [QW-1:0] v);
        logic [QW:0] f;
        f = ({1'b0, v} + (QW+1)'(128)) >> 8;
        return (f > (QW+1)'(MAX_FIXED)) ? MAX_FIXED : f[15:0];
    endfunction

    function automatic logic [7:0] byte_of_q16(input logic [QW-1:0] v);
        logic [QW:0] b;
        b = ({1'b0, v} + (QW+1)'(32768)) >> 16;
        return (b > (QW+1)'(FULL_BYTE)) ? FULL_BYTE : b[7:0];
    endfunction

    tlbp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign pipe_en  = m_tready | ~m_tvalid_reg;
    assign s_tready = pipe_en;
    assign cfg_ok   = (cfg.layer_count >= 3'd2) && (cfg.layer_count <= 3'(MAX_LAYERS)) &&
                      ({1'b0, cfg.paint_layer} < cfg.layer_count);
    assign s_dist   = s_tdata[15:0];

    always_comb begin
        s0_next        = '0;
        s0_next.vld    = s_tvalid;
        s0_next.cov[0] = s_tdata[31:16];
        s0_next.cov[1] = s_tdata[47:32];
        s0_next.cov[2] = s_tdata[63:48];
        s0_next.ok     = cfg_ok && (cfg.brush_radius != 16'd0) &&
                         (s_dist < cfg.brush_radius);
        s0_diff_next   = cfg.brush_radius - s_dist;
    end

    always_comb begin
        diva_num    = '0;
        diva_num[0] = NUM_W'({s0_diff_reg, 16'h0000});
    end

    tlbp_div u_div_ramp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .num     (diva_num),
        .den     (DW'(cfg.brush_radius)),
        .tag_in  (s0_reg),
        .quo     (diva_quo),
        .tag_out (diva_tag)
    );

    tlbp_weight u_weight (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .cfg     (cfg),
        .tag_in  (diva_tag),
        .t_quo   (diva_quo[0]),
        .tag_out (w_tag)
    );

    always_comb begin
        logic [CW-1:0]        cl;
        logic [CW-1:0]        tgt;
        logic signed [SW-1:0] diff;
        s4_next        = w_tag;
        cl             = w_tag.c[cfg.paint_layer];
        tgt            = cfg.paint_toward_full ? FULL_Q16 : '0;
        diff           = $signed({2'b00, tgt}) - $signed({2'b00, cl});
        prod_next      = diff * $signed({1'b0, w_tag.st});
        s4_next.others = w_tag.total - SW'(cl);
    end

    always_comb begin
        logic [43:0]   mag;
        logic [43:0]   rnd;
        logic [SW-1:0] chx;
        s5_next = s4_reg;
        mag     = prod_reg[43] ? 44'(-prod_reg) : 44'(prod_reg);
        rnd     = (mag + 44'd32768) >> 16;
        chx     = {1'b0, rnd[QW-1:0]};
        s5_next.change = prod_reg[43] ? -chx : chx;
        s5_next.mod    = s4_reg.ok && (rnd[QW-1:0] != '0);
    end

    always_comb begin
        logic [SW-1:0] chabs;
        s6_next = s5_reg;
        chabs   = s5_reg.change[SW-1] ? -s5_reg.change : s5_reg.change;
        for (int l = 0; l < MAX_LAYERS; l++) begin
            mul_next[l] = 49'(chabs[QW-1:0]) * 49'(s5_reg.c[l]);
        end
    end

    always_comb begin
        for (int l = 0; l < MAX_LAYERS; l++) begin
            divb_num[l] = NUM_W'(mul_reg[l]) + NUM_W'(s6_reg.others >> 1);
        end
    end

    tlbp_div u_div_share (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .num     (divb_num),
        .den     (DW'(s6_reg.others)),
        .tag_in  (s6_reg),
        .quo     (divb_quo),
        .tag_out (divb_tag)
    );

    always_comb begin
        logic signed [27:0] v;
        logic signed [27:0] chs;
        logic signed [27:0] qs;
        logic               neg;
        logic [1:0]         sink;
        s7_next = divb_tag;
        neg     = divb_tag.change[SW-1];
        chs     = {{2{divb_tag.change[SW-1]}}, divb_tag.change};
        sink    = (cfg.paint_layer == 2'd0) ? 2'd1 : 2'd0;
        for (int l = 0; l < MAX_LAYERS; l++) begin
            v  = $signed({4'b0000, divb_tag.c[l]});
            qs = $signed({3'b000, divb_quo[l]});
            if (!(3'(l) < cfg.layer_count)) begin
                v = '0;
            end else if (2'(l) == cfg.paint_layer) begin
                v = v + chs;
            end else if (divb_tag.others > EPS_Q16) begin
                v = neg ? (v + qs) : (v - qs);
            end else if (!neg) begin
                v = '0;
            end else if (2'(l) == sink) begin
                v = v - chs;
            end
            if (v < 0) begin
                s7_next.c[l] = '0;
            end else if (v > $signed({4'b0000, FULL_Q16})) begin
                s7_next.c[l] = FULL_Q16;
            end else begin
                s7_next.c[l] = v[CW-1:0];
            end
        end
    end

    always_comb begin
        s8_next       = s7_reg;
        s8_next.after = SW'(s7_reg.c[0]) + SW'(s7_reg.c[1]) +
                        SW'(s7_reg.c[2]) + SW'(s7_reg.c[3]);
    end

    always_comb begin
        logic [31:0] scaled;
        for (int l = 0; l < MAX_LAYERS; l++) begin
            scaled      = 32'(s8_reg.c[l]) * 32'(FULL_BYTE);
            divc_num[l] = NUM_W'({scaled, 16'h0000}) + NUM_W'(s8_reg.after >> 1);
        end
    end

    tlbp_div u_div_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .num     (divc_num),
        .den     (DW'(s8_reg.after)),
        .tag_in  (s8_reg),
        .quo     (divc_quo),
        .tag_out (divc_tag)
    );

    always_comb begin
        logic          empty;
        logic          renorm;
        logic [QW-1:0] cf;
        logic [15:0]   sv;
        empty  = (divc_tag.after <= EPS_Q16);
        renorm = (divc_tag.after > SW'(FULL_Q16) + EPS_Q16) ||
                 (divc_tag.after < SW'(FULL_Q16) - EPS_Q16);
        for (int k = 0; k < 3; k++) begin
            if (empty) begin
                cf = '0;
            end else if (renorm) begin
                cf = divc_quo[k+1];
            end else begin
                cf = {1'b0, divc_tag.c[k+1]};
            end
            sv = sat_fixed(divc_tag.cov[k]);
            if (divc_tag.mod && (3'(k + 1) < cfg.layer_count)) begin
                m_tdata_next[16*k +: 16]    = fixed_of_q16(cf);
                m_tdata_next[48 + 8*k +: 8] = byte_of_q16(cf);
            end else begin
                m_tdata_next[16*k +: 16]    = sv;
                m_tdata_next[48 + 8*k +: 8] = byte_of_fixed(sv);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_reg.vld   <= 1'b0;
            s4_reg.vld   <= 1'b0;
            s5_reg.vld   <= 1'b0;
            s6_reg.vld   <= 1'b0;
            s7_reg.vld   <= 1'b0;
            s8_reg.vld   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            s0_reg       <= s0_next;
            s0_diff_reg  <= s0_diff_next;
            s4_reg       <= s4_next;
            prod_reg     <= prod_next;
            s5_reg       <= s5_next;
            s6_reg       <= s6_next;
            mul_reg      <= mul_next;
            s7_reg       <= s7_next;
            s8_reg       <= s8_next;
            m_tvalid_reg <= divc_tag.vld;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= divc_tag.mod;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
